### rtl/tibd_pkg.sv
`timescale 1ns / 1ps

package tibd_pkg;

   localparam int TPM_W      = 24;
   localparam int BPM_W      = 10;
   localparam int INTERVAL_W = 16;
   localparam int DIGIT_W    = 4;
   localparam int SEG_W      = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [TPM_W-1:0] TPM_RESET = 24'd937500;
   localparam logic [BPM_W-1:0] MIN_RESET = 10'd40;
   localparam logic [BPM_W-1:0] MAX_RESET = 10'd999;

   // register index codes, byte address is 4 * index
   localparam logic [1:0] REG_TPM = 2'd0;
   localparam logic [1:0] REG_MIN = 2'd1;
   localparam logic [1:0] REG_MAX = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_UPDATE,
      ST_HUNDREDS,
      ST_TENS,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // segment a in bit 7, blank for codes that are not a digit
   function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] seg;
      case (digit)
         4'd0:    seg = 8'hFC;
         4'd1:    seg = 8'h60;
         4'd2:    seg = 8'hDA;
         4'd3:    seg = 8'hF2;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'hB6;
         4'd6:    seg = 8'hBE;
         4'd7:    seg = 8'hE0;
         4'd8:    seg = 8'hFE;
         4'd9:    seg = 8'hF6;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

### rtl/tibd_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module tibd_div (
   input  logic                                clock,
   input  logic                                reset,
   input  tibd_pkg::div_ctrl_type              ctrl,
   input  logic [tibd_pkg::TPM_W-1:0]          dividend,
   input  logic [tibd_pkg::INTERVAL_W-1:0]     divisor,
   output tibd_pkg::div_stat_type              stat,
   output logic [tibd_pkg::TPM_W-1:0]          quotient
);

   localparam int STEPS = tibd_pkg::TPM_W;
   localparam int CNT_W = $clog2(STEPS);
   localparam int DW    = tibd_pkg::INTERVAL_W;

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [STEPS-1:0] q_ff, q_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    dsr_ff, dsr_in;
   logic [DW:0]      shifted;
   logic [DW+1:0]    diff;
   logic             last;

   assign shifted = {rem_ff, q_ff[STEPS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};
   assign last    = (cnt_ff == CNT_W'(STEPS - 1));

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DW+1]) begin
            rem_in = diff[DW-1:0];
            q_in   = {q_ff[STEPS-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            q_in   = {q_ff[STEPS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff & last;
   assign quotient  = q_ff;

endmodule

### rtl/tap_interval_to_bpm_display.sv
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req_      in         req_valid / req_ready  interval_ticks
// rsp_      out        rsp_valid / rsp_ready  shown_bpm, accepted, digits, segments
// csr_      in         apb write / read       ticks_per_minute, min_bpm, max_bpm
//
// an item goes from accept to next accept through the accept, the bit-serial divider, the
// update, the hundreds and tens states that take 100 and then 10 off the shown value while
// it fits, each ending on a failed check, and the load of the result; a zero interval skips the divider
// reset is synchronous: tempo state clears, registers take their defaults
// a waiting result holds in the output register while the next item is taken; a stalled
// result keeps the following one in the load state and blocks the input

module tap_interval_to_bpm_display (
   input  logic                                  clock,
   input  logic                                  reset,
   // input item
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [tibd_pkg::INTERVAL_W-1:0]       req_interval_ticks,
   // result item
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [tibd_pkg::BPM_W-1:0]            rsp_shown_bpm,
   output logic                                  rsp_accepted,
   output logic [tibd_pkg::DIGIT_W-1:0]          rsp_hundreds_digit,
   output logic [tibd_pkg::DIGIT_W-1:0]          rsp_tens_digit,
   output logic [tibd_pkg::DIGIT_W-1:0]          rsp_ones_digit,
   output logic [tibd_pkg::SEG_W-1:0]            rsp_hundreds_segments,
   output logic [tibd_pkg::SEG_W-1:0]            rsp_tens_segments,
   output logic [tibd_pkg::SEG_W-1:0]            rsp_ones_segments,
   // configuration
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tibd_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [tibd_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [tibd_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int BW = tibd_pkg::BPM_W;
   localparam int DW = tibd_pkg::DIGIT_W;
   localparam int TW = tibd_pkg::TPM_W;

   // configuration registers
   logic [TW-1:0] tpm_ff;
   logic [BW-1:0] min_ff;
   logic [BW-1:0] max_ff;
   logic [1:0]    reg_idx;
   logic          csr_wr;

   // tempo state
   logic [BW-1:0] prev_ff, prev_in;
   logic [1:0]    count_ff, count_in;
   logic [BW-1:0] disp_ff, disp_in;

   // working registers
   tibd_pkg::state_type state_ff, state_in;
   logic          zero_ff, zero_in;
   logic          ok_ff, ok_in;
   logic [BW-1:0] val_ff, val_in;
   logic [DW-1:0] h_ff, h_in;
   logic [DW-1:0] t_ff, t_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] rsp_bpm_ff, rsp_bpm_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic [DW-1:0] rsp_h_ff, rsp_h_in;
   logic [DW-1:0] rsp_t_ff, rsp_t_in;
   logic [DW-1:0] rsp_o_ff, rsp_o_in;

   // divider link
   tibd_pkg::div_ctrl_type div_ctrl;
   tibd_pkg::div_stat_type div_stat;
   logic [TW-1:0]          quotient;

   // shared subtract unit for the digit split
   logic [BW-1:0] sub_k;
   logic [BW:0]   sub_diff;
   logic          sub_fits;

   // update path
   logic          in_range;
   logic [BW:0]   avg_sum;
   logic          req_take;
   logic          rsp_free;

   assign req_take = req_valid & req_ready;
   assign rsp_free = ~rsp_valid_ff | rsp_ready;

   // ---------------- configuration port ----------------
   assign reg_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff <= tibd_pkg::TPM_RESET;
         min_ff <= tibd_pkg::MIN_RESET;
         max_ff <= tibd_pkg::MAX_RESET;
      end else if (csr_wr) begin
         case (reg_idx)
            tibd_pkg::REG_TPM: tpm_ff <= csr_pwdata[TW-1:0];
            tibd_pkg::REG_MIN: min_ff <= csr_pwdata[BW-1:0];
            tibd_pkg::REG_MAX: max_ff <= csr_pwdata[BW-1:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         tibd_pkg::REG_TPM: csr_prdata = {{(tibd_pkg::CSR_DATA_W-TW){1'b0}}, tpm_ff};
         tibd_pkg::REG_MIN: csr_prdata = {{(tibd_pkg::CSR_DATA_W-BW){1'b0}}, min_ff};
         tibd_pkg::REG_MAX: csr_prdata = {{(tibd_pkg::CSR_DATA_W-BW){1'b0}}, max_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- divider ----------------
   tibd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (tpm_ff),
      .divisor  (req_interval_ticks),
      .stat     (div_stat),
      .quotient (quotient)
   );

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tibd_pkg::ST_IDLE: begin
            if (req_valid) begin
               // zero interval goes straight to the update as a reject
               state_in = (req_interval_ticks == '0) ? tibd_pkg::ST_UPDATE
                                                    : tibd_pkg::ST_DIVIDE;
            end
         end
         tibd_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = tibd_pkg::ST_UPDATE;
            end
         end
         tibd_pkg::ST_UPDATE:   state_in = tibd_pkg::ST_HUNDREDS;
         tibd_pkg::ST_HUNDREDS: begin
            if (!sub_fits) begin
               state_in = tibd_pkg::ST_TENS;
            end
         end
         tibd_pkg::ST_TENS: begin
            if (!sub_fits) begin
               state_in = tibd_pkg::ST_LOAD;
            end
         end
         tibd_pkg::ST_LOAD: begin
            if (rsp_free) begin
               state_in = tibd_pkg::ST_IDLE;
            end
         end
         default: state_in = tibd_pkg::ST_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_ready      = (state_ff == tibd_pkg::ST_IDLE);
      div_ctrl.start = (state_ff == tibd_pkg::ST_IDLE) & req_valid
                       & (req_interval_ticks != '0);
      sub_k          = (state_ff == tibd_pkg::ST_HUNDREDS) ? BW'(100) : BW'(10);
   end

   // ---------------- datapath ----------------
   assign sub_diff = {1'b0, val_ff} - {1'b0, sub_k};
   assign sub_fits = ~sub_diff[BW];

   assign in_range = ~zero_ff
                     & (quotient >= {{(TW-BW){1'b0}}, min_ff})
                     & (quotient <= {{(TW-BW){1'b0}}, max_ff});
   assign avg_sum  = {1'b0, quotient[BW-1:0]} + {1'b0, prev_ff};

   always_comb begin
      zero_in      = zero_ff;
      ok_in        = ok_ff;
      val_in       = val_ff;
      h_in         = h_ff;
      t_in         = t_ff;
      prev_in      = prev_ff;
      count_in     = count_ff;
      disp_in      = disp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_bpm_in   = rsp_bpm_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_t_in     = rsp_t_ff;
      rsp_o_in     = rsp_o_ff;
      case (state_ff)
         tibd_pkg::ST_IDLE: begin
            if (req_take) begin
               zero_in = (req_interval_ticks == '0);
            end
         end
         tibd_pkg::ST_UPDATE: begin
            ok_in = in_range;
            val_in = disp_ff;
            if (in_range) begin
               // first two beats show the raw tempo, later ones the mean
               if (count_ff < 2'd2) begin
                  disp_in  = quotient[BW-1:0];
                  val_in   = quotient[BW-1:0];
                  count_in = count_ff + 2'd1;
               end else begin
                  disp_in = avg_sum[BW:1];
                  val_in  = avg_sum[BW:1];
               end
               prev_in = quotient[BW-1:0];
            end
            h_in = '0;
            t_in = '0;
         end
         tibd_pkg::ST_HUNDREDS: begin
            if (sub_fits) begin
               val_in = sub_diff[BW-1:0];
               h_in   = h_ff + DW'(1);
            end
         end
         tibd_pkg::ST_TENS: begin
            if (sub_fits) begin
               val_in = sub_diff[BW-1:0];
               t_in   = t_ff + DW'(1);
            end
         end
         tibd_pkg::ST_LOAD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_bpm_in   = disp_ff;
               rsp_ok_in    = ok_ff;
               rsp_h_in     = h_ff;
               rsp_t_in     = t_ff;
               rsp_o_in     = val_ff[DW-1:0];  // remainder is below ten here
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tibd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         count_ff     <= '0;
         disp_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         disp_ff      <= disp_in;
      end
      zero_ff    <= zero_in;
      ok_ff      <= ok_in;
      val_ff     <= val_in;
      h_ff       <= h_in;
      t_ff       <= t_in;
      rsp_bpm_ff <= rsp_bpm_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_h_ff   <= rsp_h_in;
      rsp_t_ff   <= rsp_t_in;
      rsp_o_ff   <= rsp_o_in;
   end

   // ---------------- result port ----------------
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_shown_bpm         = rsp_bpm_ff;
   assign rsp_accepted          = rsp_ok_ff;
   assign rsp_hundreds_digit    = rsp_h_ff;
   assign rsp_tens_digit        = rsp_t_ff;
   assign rsp_ones_digit        = rsp_o_ff;
   assign rsp_hundreds_segments = tibd_pkg::seg_of(rsp_h_ff);
   assign rsp_tens_segments     = tibd_pkg::seg_of(rsp_t_ff);
   assign rsp_ones_segments     = tibd_pkg::seg_of(rsp_o_ff);

endmodule

### rtl/tibd_check.sv
`timescale 1ns / 1ps

module tibd_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [tibd_pkg::BPM_W-1:0]        rsp_shown_bpm,
   input logic [tibd_pkg::DIGIT_W-1:0]      rsp_hundreds_digit,
   input logic [tibd_pkg::DIGIT_W-1:0]      rsp_tens_digit,
   input logic [tibd_pkg::DIGIT_W-1:0]      rsp_ones_digit
);

   logic [tibd_pkg::BPM_W-1:0] recombined;

   assign recombined = {6'd0, rsp_hundreds_digit} * 10'd100
                     + {6'd0, rsp_tens_digit} * 10'd10
                     + {6'd0, rsp_ones_digit};

   // result holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_shown_bpm))
      else $error("result dropped or changed while stalled");

   // block is busy right after taking an item
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   // lower digits are decimal
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tens_digit <= 4'd9 && rsp_ones_digit <= 4'd9)
      else $error("digit out of range");

   // digits recombine to the shown tempo
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hundreds_digit <= 4'd9 |-> recombined == rsp_shown_bpm)
      else $error("digits do not match shown bpm");

endmodule

bind tap_interval_to_bpm_display tibd_check u_tibd_check (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_shown_bpm      (rsp_shown_bpm),
   .rsp_hundreds_digit (rsp_hundreds_digit),
   .rsp_tens_digit     (rsp_tens_digit),
   .rsp_ones_digit     (rsp_ones_digit)
);

### test/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int HALF_PERIOD  = 4;
   localparam int CYCLE_LIMIT  = 1_000_000;
   // long enough for anything still in flight to finish
   localparam int SETTLE       = 120;
   // receiver pressure: after this many results it holds off for a long stretch
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 400;
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_ITEMS  = 235;

   // one result item as the block presents it
   typedef struct packed {
      logic [tibd_pkg::BPM_W-1:0]   shown_bpm;
      logic                         accepted;
      logic [tibd_pkg::DIGIT_W-1:0] hundreds_digit;
      logic [tibd_pkg::DIGIT_W-1:0] tens_digit;
      logic [tibd_pkg::DIGIT_W-1:0] ones_digit;
      logic [tibd_pkg::SEG_W-1:0]   hundreds_segments;
      logic [tibd_pkg::SEG_W-1:0]   tens_segments;
      logic [tibd_pkg::SEG_W-1:0]   ones_segments;
   } tempo_result_type;

   // tempo predictor plus the queue of displays still owed by the block
   class tempo_scoreboard;
      logic [tibd_pkg::TPM_W-1:0]   ticks_per_min;
      logic [tibd_pkg::BPM_W-1:0]   lower_bpm;
      logic [tibd_pkg::BPM_W-1:0]   upper_bpm;
      logic [tibd_pkg::BPM_W-1:0]   last_beat_bpm;
      logic [tibd_pkg::BPM_W-1:0]   display_bpm;
      int unsigned                  beats_taken;
      tempo_result_type             pending[$];
      int unsigned                  errors;
      int unsigned                  results_seen;

      function void clear();
         ticks_per_min = tibd_pkg::TPM_RESET;
         lower_bpm     = tibd_pkg::MIN_RESET;
         upper_bpm     = tibd_pkg::MAX_RESET;
         last_beat_bpm = '0;
         display_bpm   = '0;
         beats_taken   = 0;
         errors        = 0;
         results_seen  = 0;
         pending.delete();
      endfunction

      function void set_register(logic [1:0] index, logic [tibd_pkg::CSR_DATA_W-1:0] value);
         case (index)
            tibd_pkg::REG_TPM: ticks_per_min = value[tibd_pkg::TPM_W-1:0];
            tibd_pkg::REG_MIN: lower_bpm     = value[tibd_pkg::BPM_W-1:0];
            tibd_pkg::REG_MAX: upper_bpm     = value[tibd_pkg::BPM_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [tibd_pkg::SEG_W-1:0] glyph(int unsigned digit);
         logic [tibd_pkg::SEG_W-1:0] pattern;
         case (digit)
            0:       pattern = 8'hFC;
            1:       pattern = 8'h60;
            2:       pattern = 8'hDA;
            3:       pattern = 8'hF2;
            4:       pattern = 8'h66;
            5:       pattern = 8'hB6;
            6:       pattern = 8'hBE;
            7:       pattern = 8'hE0;
            8:       pattern = 8'hFE;
            9:       pattern = 8'hF6;
            default: pattern = 8'h00;   // blank past nine
         endcase
         return pattern;
      endfunction

      // an interval went into the block: update the tempo and queue the display
      function void note_interval(logic [tibd_pkg::INTERVAL_W-1:0] ticks);
         logic [31:0]      beat_bpm;
         logic [31:0]      mean_bpm;
         logic             ok;
         int unsigned      value;
         tempo_result_type want;
         ok = 1'b0;
         if (ticks != '0) begin
            beat_bpm = {8'd0, ticks_per_min} / {16'd0, ticks};
            if (beat_bpm >= {22'd0, lower_bpm} && beat_bpm <= {22'd0, upper_bpm}) begin
               ok = 1'b1;
               if (beats_taken < 2) begin
                  display_bpm = beat_bpm[tibd_pkg::BPM_W-1:0];
                  beats_taken++;
               end else begin
                  mean_bpm    = (beat_bpm + {22'd0, last_beat_bpm}) / 2;
                  display_bpm = mean_bpm[tibd_pkg::BPM_W-1:0];
               end
               last_beat_bpm = beat_bpm[tibd_pkg::BPM_W-1:0];
            end
         end
         value                  = 32'(display_bpm);
         want.shown_bpm         = display_bpm;
         want.accepted          = ok;
         want.hundreds_digit    = tibd_pkg::DIGIT_W'(value / 100);
         want.tens_digit        = tibd_pkg::DIGIT_W'((value % 100) / 10);
         want.ones_digit        = tibd_pkg::DIGIT_W'(value % 10);
         want.hundreds_segments = glyph(value / 100);
         want.tens_segments     = glyph((value % 100) / 10);
         want.ones_segments     = glyph(value % 10);
         pending.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(tempo_result_type got);
         tempo_result_type want;
         results_seen++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: display item with none expected, expected none, got bpm %0d",
                     $time, got.shown_bpm);
            return;
         end
         want = pending.pop_front();
         compare_field("shown_bpm", 32'(want.shown_bpm), 32'(got.shown_bpm));
         compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
         compare_field("hundreds_digit", 32'(want.hundreds_digit),
                       32'(got.hundreds_digit));
         compare_field("tens_digit", 32'(want.tens_digit), 32'(got.tens_digit));
         compare_field("ones_digit", 32'(want.ones_digit), 32'(got.ones_digit));
         compare_field("hundreds_segments", 32'(want.hundreds_segments),
                       32'(got.hundreds_segments));
         compare_field("tens_segments", 32'(want.tens_segments),
                       32'(got.tens_segments));
         compare_field("ones_segments", 32'(want.ones_segments),
                       32'(got.ones_segments));
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [tibd_pkg::INTERVAL_W-1:0] req_interval_ticks;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [tibd_pkg::BPM_W-1:0]      rsp_shown_bpm;
   logic                            rsp_accepted;
   logic [tibd_pkg::DIGIT_W-1:0]    rsp_hundreds_digit;
   logic [tibd_pkg::DIGIT_W-1:0]    rsp_tens_digit;
   logic [tibd_pkg::DIGIT_W-1:0]    rsp_ones_digit;
   logic [tibd_pkg::SEG_W-1:0]      rsp_hundreds_segments;
   logic [tibd_pkg::SEG_W-1:0]      rsp_tens_segments;
   logic [tibd_pkg::SEG_W-1:0]      rsp_ones_segments;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [tibd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [tibd_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [tibd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   tempo_scoreboard tempo_board = new();
   int unsigned     intervals_sent;
   int unsigned     cycle_count;

   tap_interval_to_bpm_display i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_interval_ticks    (req_interval_ticks),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_shown_bpm         (rsp_shown_bpm),
      .rsp_accepted          (rsp_accepted),
      .rsp_hundreds_digit    (rsp_hundreds_digit),
      .rsp_tens_digit        (rsp_tens_digit),
      .rsp_ones_digit        (rsp_ones_digit),
      .rsp_hundreds_segments (rsp_hundreds_segments),
      .rsp_tens_segments     (rsp_tens_segments),
      .rsp_ones_segments     (rsp_ones_segments),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // sender gap, with every fourth hundred items sent back to back
   function automatic int draw_gap();
      if ((intervals_sent / 100) % 4 == 3)
         return 0;
      return $urandom_range(0, 9);
   endfunction

   // offer one interval after a random gap and hold it until taken;
   // valid is only dropped when a gap follows, so it never toggles in one step
   task automatic send_interval(logic [tibd_pkg::INTERVAL_W-1:0] ticks);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_interval_ticks <= ticks;
      do
         @(posedge clock);
      while (!req_ready);
      tempo_board.note_interval(ticks);
      intervals_sent++;
   endtask

   // apb transfer: setup cycle, access cycle, then back to idle
   task automatic csr_transfer(logic write, logic [1:0] index,
                               logic [tibd_pkg::CSR_DATA_W-1:0] data,
                               output logic [tibd_pkg::CSR_DATA_W-1:0] read_data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= tibd_pkg::CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      read_data = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write a register and read it straight back
   task automatic write_register(logic [1:0] index, logic [tibd_pkg::CSR_DATA_W-1:0] value);
      logic [tibd_pkg::CSR_DATA_W-1:0] readback;
      csr_transfer(1'b1, index, value, readback);
      tempo_board.set_register(index, value);
      csr_transfer(1'b0, index, '0, readback);
      tempo_board.compare_field("register readback", value, readback);
   endtask

   task automatic configure(logic [tibd_pkg::TPM_W-1:0] tpm, logic [tibd_pkg::BPM_W-1:0] lo,
                            logic [tibd_pkg::BPM_W-1:0] hi);
      write_register(tibd_pkg::REG_TPM, tibd_pkg::CSR_DATA_W'(tpm));
      write_register(tibd_pkg::REG_MIN, tibd_pkg::CSR_DATA_W'(lo));
      write_register(tibd_pkg::REG_MAX, tibd_pkg::CSR_DATA_W'(hi));
   endtask

   // wait until every owed display has come back, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tempo_board.pending.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // random limits and tick rate, then mostly intervals that land inside the limits
   task automatic random_phase(int count);
      logic [tibd_pkg::TPM_W-1:0]      tpm;
      logic [tibd_pkg::BPM_W-1:0]      lo;
      logic [tibd_pkg::BPM_W-1:0]      hi;
      logic [tibd_pkg::INTERVAL_W-1:0] ticks;
      int unsigned                     slowest;
      int unsigned                     floor_bpm;
      int unsigned                     target;
      int unsigned                     pick;
      case ($urandom_range(0, 3))
         0:       tpm = tibd_pkg::TPM_RESET;
         1:       tpm = tibd_pkg::TPM_W'($urandom_range(1, 24'hFFFFFF));
         2:       tpm = tibd_pkg::TPM_W'($urandom_range(1000, 200000));
         default: tpm = tibd_pkg::TPM_W'($urandom_range(60000, 3000000));
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         // crossed limits, nothing gets accepted
         lo = tibd_pkg::BPM_W'($urandom_range(500, 999));
         hi = tibd_pkg::BPM_W'($urandom_range(0, lo - 1));
      end else begin
         lo = tibd_pkg::BPM_W'($urandom_range(0, 300));
         hi = (pick == 1) ? tibd_pkg::BPM_W'($urandom_range(1000, 1023))
                          : tibd_pkg::BPM_W'($urandom_range(lo, 999));
      end
      configure(tpm, lo, hi);
      floor_bpm = tpm / 65535;
      slowest   = (lo > floor_bpm + 1) ? lo : floor_bpm + 1;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 80 && slowest <= hi && slowest <= tpm) begin
            target = $urandom_range(slowest, hi);
            ticks  = (target == 0) ? tibd_pkg::INTERVAL_W'($urandom_range(1, 65535))
                                   : tibd_pkg::INTERVAL_W'(tpm / target);
            if (ticks == '0)
               ticks = tibd_pkg::INTERVAL_W'(1);
         end else if (pick < 90) begin
            ticks = tibd_pkg::INTERVAL_W'($urandom_range(0, 65535));
         end else if (pick < 95) begin
            ticks = '0;
         end else begin
            ticks = tibd_pkg::INTERVAL_W'($urandom_range(1, 3));
         end
         send_interval(ticks);
      end
      drain();
   endtask

   // result side: random stall per item, quiet stretches, and one long hold-off
   initial begin : result_sink
      int stall;
      tempo_result_type got;
      rsp_ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         if (tempo_board.results_seen == HOLD_AT)
            stall = HOLD_CYCLES;
         else if ((tempo_board.results_seen / 150) % 3 == 2)
            stall = 0;
         else
            stall = $urandom_range(0, 9);
         @(negedge clock);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do
            @(posedge clock);
         while (!rsp_valid);
         got.shown_bpm         = rsp_shown_bpm;
         got.accepted          = rsp_accepted;
         got.hundreds_digit    = rsp_hundreds_digit;
         got.tens_digit        = rsp_tens_digit;
         got.ones_digit        = rsp_ones_digit;
         got.hundreds_segments = rsp_hundreds_segments;
         got.tens_segments     = rsp_tens_segments;
         got.ones_segments     = rsp_ones_segments;
         tempo_board.check_result(got);
      end
   end

   initial begin : stimulus
      logic [tibd_pkg::INTERVAL_W-1:0] opening[$];
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_interval_ticks = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      cycle_count        = 0;
      intervals_sent     = 0;
      tempo_board.clear();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default limits: zero interval, too fast, too slow, first two beats,
      // then the running mean, with the edges of the window either side
      opening = '{16'd0, 16'd1, 16'hFFFF, 16'd939, 16'd23437, 16'd23438, 16'd938,
                  16'd1875, 16'd0, 16'h8000, 16'h5555, 16'hAAAA, 16'd9375};
      foreach (opening[i])
         send_interval(opening[i]);
      drain();

      // widest tick rate with max above 999: hundreds digit goes past nine
      configure(24'hFFFFFF, 10'd0, 10'd1023);
      send_interval(16'd16385);
      send_interval(16'd16385);
      send_interval(16'hFFFF);
      send_interval(16'd1);
      drain();

      // zero tick rate: bpm of zero only passes while min is zero
      configure(24'd0, 10'd0, 10'd999);
      send_interval(16'd5);
      send_interval(16'd0);
      drain();
      write_register(tibd_pkg::REG_MIN, tibd_pkg::CSR_DATA_W'(10'd1));
      send_interval(16'd7);
      drain();

      // crossed limits reject everything
      configure(tibd_pkg::TPM_RESET, 10'd500, 10'd100);
      send_interval(16'd1875);
      send_interval(16'd9375);
      drain();

      // degenerate windows at both ends
      configure(24'd1, 10'd0, 10'd0);
      send_interval(16'd1);
      send_interval(16'd2);
      drain();
      configure(24'd999, 10'd999, 10'd999);
      send_interval(16'd1);
      send_interval(16'd2);
      drain();

      for (int p = 0; p < RAND_PHASES; p++)
         random_phase(PHASE_ITEMS);

      if (tempo_board.errors == 0 && tempo_board.pending.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
